### rtl/mbte_pkg.sv
// Constants and helper functions for the MJD/BCD time stamp to epoch converter.
// Used by mjd_bcd_time_to_epoch; depends on nothing else.

package mbte_pkg;

  // Date range and epoch base
  localparam logic [15:0] MJD_Y2000      = 16'd51544;
  localparam logic [31:0] SECS_1970_2000 = 32'd946684800;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'(365 * 4 + 1);
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;

  // Year estimate: y = (20*mjd - 301564) / 7305, i.e. (mjd - 15078.2) / 365.25
  localparam logic [20:0] Y_OFFSET = 21'd301564;
  localparam logic [12:0] Y_DIV    = 13'd7305;
  // floor(2^32 / 7305); the quotient it gives is low by at most one
  localparam logic [19:0] Y_RECIP  = 20'((64'd1 << 32) / 64'd7305);

  // Day offset of the year start: mjd - 14956
  localparam logic [16:0] MJD_BASE = 17'd14956;

  // Month index: count of j in 1..15 with 10000*r - 1000 >= 306001*j
  localparam int M_MAX = 15;

  localparam logic [3:0] M_JAN_NEXT = 4'd14;
  localparam logic [3:0] M_FEB_NEXT = 4'd15;

  // floor(30.6001 * m) for m = 0..15
  localparam logic [8:0] MONTH_DAYS [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // Smallest r that reaches month step j (ceiling of (306001*j + 1000) / 10000)
  function automatic logic [9:0] month_thresh(input int j);
    return 10'((306001 * j + 1000 + 9999) / 10000);
  endfunction

  // floor(30.6001 * m)
  function automatic logic [8:0] month_days(input logic [3:0] m);
    return MONTH_DAYS[m];
  endfunction

  // Two BCD digits to binary, digits unchecked
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

  // Cumulative days at each month start within a four-year cycle (leap year first)
  localparam logic [10:0] CUM_DAYS [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

endpackage

### rtl/mjd_bcd_time_to_epoch.sv
// MJD date plus BCD hour/minute/second to seconds since 1970, eight-stage pipeline.
// Depends on mbte_pkg.
//
//   channel  signals                                          direction
//   input    in_valid, in_stall, mjd, hour_bcd, minute_bcd,   in (in_stall out)
//            second_bcd
//   output   out_valid, out_stall, epoch_seconds,             out (out_stall in)
//            date_invalid
//
// One transaction per cycle unless out_stall holds the pipe. The result passes through
// the stage chain in order: date scale and BCD decode, reciprocal multiply, quotient fix,
// year-day multiply, month search, day split, day sum, seconds multiply.
// rst (synchronous) clears the stage valid bits only; payload is not reset.
// While the output is held by out_stall the whole pipe freezes and in_stall is high.

module mjd_bcd_time_to_epoch (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] mjd,
  input  logic [7:0]  hour_bcd,
  input  logic [7:0]  minute_bcd,
  input  logic [7:0]  second_bcd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] epoch_seconds,
  output logic        date_invalid
);
  import mbte_pkg::*;

  localparam int STAGES = 8;

  logic              en;
  logic [STAGES:1]   v;

  // stage 1
  logic [19:0] s1_n;
  logic [15:0] s1_mjd;
  logic        s1_bad;
  logic [7:0]  s1_h, s1_m, s1_s;
  // stage 2
  logic [39:0] s2_prod;
  logic [7:0]  s2_q0;
  logic [19:0] s2_n;
  logic [15:0] s2_mjd;
  logic        s2_bad;
  logic [19:0] s2_hms;
  // stage 3
  logic [20:0] s3_rem;
  logic [7:0]  s3_y;
  logic [15:0] s3_mjd;
  logic        s3_bad;
  logic [19:0] s3_hms;
  // stage 4
  logic [18:0] s4_yd_full;
  logic [16:0] s4_r_full;
  logic [7:0]  s4_y;
  logic [9:0]  s4_r;
  logic        s4_bad;
  logic [19:0] s4_hms;
  // stage 5
  logic [3:0]  s5_m_next;
  logic [3:0]  s5_m;
  logic [7:0]  s5_y;
  logic [9:0]  s5_r;
  logic        s5_bad;
  logic [19:0] s5_hms;
  // stage 6
  logic        s6_k;
  logic [9:0]  s6_d;
  logic [3:0]  s6_mi;
  logic [5:0]  s6_year;
  logic [3:0]  s6_month;
  logic [9:0]  s6_day;
  logic        s6_bad;
  logic [19:0] s6_hms;
  // stage 7
  logic [14:0] s7_days;
  logic        s7_bad;
  logic [19:0] s7_hms;
  // stage 8 is the output register
  logic [31:0] s8_secs;

  // Pipe advances unless a finished result is held
  assign en        = !(v[STAGES] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v[STAGES];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-1:1], in_valid};
    end
  end

  // Stage 1: scale date, decode BCD
  always_ff @(posedge clk) begin
    if (en) begin
      s1_n   <= 20'(({5'd0, mjd} << 4) + ({5'd0, mjd} << 2) - Y_OFFSET);
      s1_mjd <= mjd;
      s1_bad <= (mjd < MJD_Y2000);
      s1_h   <= bcd_to_bin(hour_bcd);
      s1_m   <= bcd_to_bin(minute_bcd);
      s1_s   <= bcd_to_bin(second_bcd);
    end
  end

  // Stage 2: reciprocal multiply for the year quotient; time of day in seconds
  assign s2_prod = {20'd0, s1_n} * {20'd0, Y_RECIP};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_q0  <= s2_prod[39:32];
      s2_n   <= s1_n;
      s2_mjd <= s1_mjd;
      s2_bad <= s1_bad;
      s2_hms <= 20'({12'd0, s1_h} * 20'd3600) + 20'({12'd0, s1_m} * 20'd60)
                + {12'd0, s1_s};
    end
  end

  // Stage 3: correct the quotient by one where the remainder is too large
  assign s3_rem = {1'b0, s2_n} - 21'({13'd0, s2_q0} * {8'd0, Y_DIV});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_y   <= s2_q0 + 8'(s3_rem >= {8'd0, Y_DIV});
      s3_mjd <= s2_mjd;
      s3_bad <= s2_bad;
      s3_hms <= s2_hms;
    end
  end

  // Stage 4: days to year start, remainder within the year
  assign s4_yd_full = 19'({11'd0, s3_y} * 19'(DAYS_PER_CYCLE));
  assign s4_r_full  = {1'b0, s3_mjd} - MJD_BASE - {1'b0, s4_yd_full[17:2]};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_y   <= s3_y;
      s4_r   <= s4_r_full[9:0];
      s4_bad <= s3_bad;
      s4_hms <= s3_hms;
    end
  end

  // Stage 5: month index by threshold compares
  always_comb begin
    s5_m_next = '0;
    for (int j = 1; j <= M_MAX; j++) begin
      s5_m_next = s5_m_next + 4'(s4_r >= month_thresh(j));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_m   <= s5_m_next;
      s5_y   <= s4_y;
      s5_r   <= s4_r;
      s5_bad <= s4_bad;
      s5_hms <= s4_hms;
    end
  end

  // Stage 6: day of month, calendar year and month, zero-based
  assign s6_k   = (s5_m == M_JAN_NEXT) || (s5_m == M_FEB_NEXT);
  assign s6_d   = s5_r - {1'b0, month_days(s5_m)};
  assign s6_mi  = s6_k ? (s5_m - 4'd13) : (s5_m - 4'd1);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_year  <= 6'(s5_y + {7'd0, s6_k} - 8'd100);
      if (s6_mi == 4'd0) begin
        s6_month <= 4'd0;
      end else if (s6_mi > 4'd12) begin
        s6_month <= 4'd11;
      end else begin
        s6_month <= s6_mi - 4'd1;
      end
      s6_day <= (s6_d != 10'd0) ? (s6_d - 10'd1) : 10'd0;
      s6_bad <= s5_bad;
      s6_hms <= s5_hms;
    end
  end

  // Stage 7: days since 2000-01-01
  always_ff @(posedge clk) begin
    if (en) begin
      s7_days <= 15'({11'd0, s6_year[5:2]} * 15'(DAYS_PER_CYCLE))
                 + {4'd0, CUM_DAYS[s6_year[1:0]][s6_month]}
                 + {5'd0, s6_day};
      s7_bad  <= s6_bad;
      s7_hms  <= s6_hms;
    end
  end

  // Stage 8: seconds since 1970
  assign s8_secs = 32'({17'd0, s7_days} * {15'd0, SECS_PER_DAY})
                   + {12'd0, s7_hms} + SECS_1970_2000;

  always_ff @(posedge clk) begin
    if (en) begin
      epoch_seconds <= s7_bad ? 32'd0 : s8_secs;
      date_invalid  <= s7_bad;
    end
  end

  // Checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_invalid |-> epoch_seconds == 32'd0)
    else $error("invalid date with nonzero seconds");

  a_valid_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && !date_invalid |-> epoch_seconds >= SECS_1970_2000)
    else $error("valid date below year-2000 base");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    en && !$past(rst) |=> out_valid == $past(v[STAGES-1]))
    else $error("valid bit lost or invented at output stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> v == $past(v))
    else $error("pipe moved while output held");

endmodule
